@@ rtl/core/bfa_pkg.sv @@
// Shared types and constants for the best-fit block allocator.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none
package bfa_pkg;
    localparam int MAX_BLOCKS   = 64;
    localparam int IDX_W        = $clog2(MAX_BLOCKS);
    localparam int CNT_W        = IDX_W + 1;
    localparam int HEADER_BYTES = 32;
    localparam int ALIGN_BYTES  = 16;
    localparam int ALIGN_SH     = 4;
    localparam int EXT_W        = 34;
    localparam logic [31:0] HEAP_RESET = 32'h8000_0000;

    localparam logic [1:0] ACT_ALLOC  = 2'd0;
    localparam logic [1:0] ACT_FREE   = 2'd1;
    localparam logic [1:0] ACT_RESIZE = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_ZERO    = 3'd1;
    localparam logic [2:0] ST_HEAP    = 3'd2;
    localparam logic [2:0] ST_DOUBLE  = 3'd3;
    localparam logic [2:0] ST_UNKNOWN = 3'd4;
    localparam logic [2:0] ST_FULL    = 3'd5;

    typedef struct packed {
        logic [31:0] offset;
        logic [31:0] size;
        logic        allocated;
        logic [15:0] stamp;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic latch;
        logic scan_rd;
        logic decide;
        logic wr_a;
        logic wr_b;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic scan_last;
        logic out_full;
    } t_dp_stat;
endpackage
`default_nettype wire

@@ rtl/core/bfa_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none
module bfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ rtl/core/bfa_ctrl.sv @@
// Sequencer of the allocator: accept, scan, decide, write back, respond.
// Depends on bfa_pkg.
`default_nettype none
module bfa_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire bfa_pkg::t_dp_stat i_stat,
    output bfa_pkg::t_cmd        o_cmd
);
    import bfa_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SCAN   = 7'b0000010,
        S_DRAIN  = 7'b0000100,
        S_DECIDE = 7'b0001000,
        S_WRA    = 7'b0010000,
        S_WRB    = 7'b0100000,
        S_OUT    = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                // No item is taken while reset is held.
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN:  n_state = S_DECIDE;
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = S_WRA;
            end
            S_WRA: begin
                o_cmd.wr_a = 1'b1;
                n_state    = S_WRB;
            end
            S_WRB: begin
                o_cmd.wr_b = 1'b1;
                n_state    = S_OUT;
            end
            S_OUT: begin
                if (!i_stat.out_full) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

@@ rtl/core/bfa_dp.sv @@
// Datapath of the allocator: descriptor table, scan, decision and result register.
// Depends on bfa_pkg and bfa_ram.
`default_nettype none
module bfa_dp (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire bfa_pkg::t_cmd i_cmd,
    output bfa_pkg::t_dp_stat  o_stat,
    input  wire logic          i_cfg_we,
    input  wire logic [31:0]   i_cfg_wdata,
    input  wire logic [1:0]    i_action,
    input  wire logic [31:0]   i_request_size,
    input  wire logic [31:0]   i_block_offset,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic [31:0]        o_result_offset,
    output logic [2:0]         o_status
);
    import bfa_pkg::*;

    // Item and allocator state.
    logic [1:0]       r_action;
    logic [31:0]      r_size, r_off, r_heap, r_bump;
    logic [15:0]      r_ctr;
    logic [CNT_W-1:0] r_used;
    logic [EXT_W-1:0] r_blk, r_nb;

    // Scan state.
    logic [IDX_W-1:0] r_rd_idx, r_ev_idx;
    logic             r_ev;
    logic             r_m_found, r_m_alloc;
    logic [IDX_W-1:0] r_m_idx;
    logic [31:0]      r_m_size;
    logic             r_bf_found;
    logic [IDX_W-1:0] r_bf_idx;
    logic [31:0]      r_bf_size, r_bf_off;
    logic [15:0]      r_bf_age;

    // Write-back plan and result.
    logic             r_need_a, r_need_b;
    logic [IDX_W-1:0] r_a_idx, r_b_idx;
    t_entry           r_a_word, r_b_word;
    logic [31:0]      r_res;
    logic [2:0]       r_st;

    t_entry           rd_word, wr_word;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [EXT_W-1:0] blk_sum;

    assign ram_we    = (i_cmd.wr_a && r_need_a) || (i_cmd.wr_b && r_need_b);
    assign ram_waddr = i_cmd.wr_a ? r_a_idx : r_b_idx;
    assign wr_word   = i_cmd.wr_a ? r_a_word : r_b_word;
    assign rd_word   = t_entry'(ram_rdata);

    bfa_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_BLOCKS)) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (wr_word),
        .i_raddr (r_rd_idx),
        .o_rdata (ram_rdata)
    );

    assign o_stat.scan_last = (r_rd_idx == IDX_W'(MAX_BLOCKS - 1));
    assign o_stat.out_full  = o_out_valid && !i_out_ready;

    assign blk_sum = {2'b00, r_bump} + EXT_W'(HEADER_BYTES + ALIGN_BYTES - 1);

    // Entries are created in table order and never removed, so an entry is valid
    // exactly when its index is below the fill count.
    logic        ev_valid, ev_match, ev_fit, ev_better;
    logic [15:0] ev_age;

    always_comb begin
        ev_valid  = r_ev && ({1'b0, r_ev_idx} < r_used);
        ev_match  = ev_valid && (rd_word.offset == r_off) && !r_m_found;
        ev_age    = r_ctr - rd_word.stamp;
        ev_fit    = ev_valid && !rd_word.allocated && (rd_word.size >= r_size);
        ev_better = !r_bf_found || (rd_word.size < r_bf_size) ||
                    ((rd_word.size == r_bf_size) && (ev_age < r_bf_age));
    end

    // Decision, taken once the scan has finished.
    logic             al_new, al_best, do_alloc, do_free;
    logic [2:0]       al_st, d_st;
    logic [31:0]      al_res, d_res;
    t_entry           free_word;

    always_comb begin
        al_new  = 1'b0;
        al_best = 1'b0;
        al_res  = '0;
        if (r_size == '0) begin
            al_st = ST_ZERO;
        end else if (r_bf_found) begin
            al_st   = ST_OK;
            al_best = 1'b1;
            al_res  = r_bf_off;
        end else if (r_nb > {2'b00, r_heap}) begin
            al_st = ST_HEAP;
        end else if (r_used >= CNT_W'(MAX_BLOCKS)) begin
            al_st = ST_FULL;
        end else begin
            al_st  = ST_OK;
            al_new = 1'b1;
            al_res = r_blk[31:0];
        end

        free_word.offset    = r_off;
        free_word.size      = r_m_size;
        free_word.allocated = 1'b0;
        free_word.stamp     = r_ctr;

        do_alloc = 1'b0;
        do_free  = 1'b0;
        d_st     = ST_OK;
        d_res    = '0;
        case (r_action)
            ACT_ALLOC: begin
                do_alloc = 1'b1;
                d_st     = al_st;
                d_res    = al_res;
            end
            ACT_FREE: begin
                if (r_off == '0) begin
                    d_st = ST_OK;
                end else if (!r_m_found) begin
                    d_st = ST_UNKNOWN;
                end else if (!r_m_alloc) begin
                    d_st = ST_DOUBLE;
                end else begin
                    do_free = 1'b1;
                end
            end
            ACT_RESIZE: begin
                if (r_off == '0) begin
                    do_alloc = 1'b1;
                    d_st     = al_st;
                    d_res    = al_res;
                end else if (!r_m_found) begin
                    d_st = ST_UNKNOWN;
                end else if (!r_m_alloc) begin
                    d_st = ST_DOUBLE;
                end else if (r_size == '0) begin
                    do_free = 1'b1;
                end else if (r_size <= r_m_size) begin
                    d_res = r_off;
                end else begin
                    // Growth: take a new block, and release the old one only on success.
                    do_alloc = 1'b1;
                    d_st     = al_st;
                    d_res    = al_res;
                    do_free  = (al_st == ST_OK);
                end
            end
            default: d_st = ST_OK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_blk <= {blk_sum[EXT_W-1:ALIGN_SH], {ALIGN_SH{1'b0}}};
        r_nb  <= r_blk + {2'b00, r_size} + EXT_W'(2 * ALIGN_BYTES);

        if (i_cmd.latch) begin
            r_action <= i_action;
            r_size   <= i_request_size;
            r_off    <= i_block_offset;
        end

        r_ev_idx <= r_rd_idx;
        if (ev_match) begin
            r_m_idx   <= r_ev_idx;
            r_m_alloc <= rd_word.allocated;
            r_m_size  <= rd_word.size;
        end
        if (ev_fit && ev_better) begin
            r_bf_idx  <= r_ev_idx;
            r_bf_size <= rd_word.size;
            r_bf_off  <= rd_word.offset;
            r_bf_age  <= ev_age;
        end

        if (i_cmd.decide) begin
            r_res    <= d_res;
            r_st     <= d_st;
            r_a_idx  <= al_best ? r_bf_idx : r_used[IDX_W-1:0];
            r_a_word <= al_best ? t_entry'{offset: r_bf_off, size: r_bf_size,
                                           allocated: 1'b1, stamp: 16'd0}
                                : t_entry'{offset: r_blk[31:0], size: r_size,
                                           allocated: 1'b1, stamp: 16'd0};
            r_b_idx  <= r_m_idx;
            r_b_word <= free_word;
        end

        if (i_cmd.load_out) begin
            o_result_offset <= r_res;
            o_status        <= r_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap      <= HEAP_RESET;
            r_bump      <= '0;
            r_ctr       <= '0;
            r_used      <= '0;
            r_rd_idx    <= '0;
            r_ev        <= 1'b0;
            r_m_found   <= 1'b0;
            r_bf_found  <= 1'b0;
            r_need_a    <= 1'b0;
            r_need_b    <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_heap <= i_cfg_wdata;
            end
            r_ev <= i_cmd.scan_rd;
            if (i_cmd.latch) begin
                r_rd_idx <= '0;
            end else if (i_cmd.scan_rd) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
            if (i_cmd.latch) begin
                r_m_found <= 1'b0;
            end else if (ev_match) begin
                r_m_found <= 1'b1;
            end
            if (i_cmd.latch) begin
                r_bf_found <= 1'b0;
            end else if (ev_fit && ev_better) begin
                r_bf_found <= 1'b1;
            end
            if (i_cmd.decide) begin
                r_need_a <= do_alloc && (al_best || al_new);
                r_need_b <= do_free;
                if (do_alloc && al_new) begin
                    r_bump <= r_nb[31:0];
                    r_used <= r_used + 1'b1;
                end
                if (do_free) begin
                    r_ctr <= r_ctr + 16'd1;
                end
            end
            if (i_cmd.load_out) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/best_fit_block_allocator_core.sv @@
// Top level of the best-fit block allocator: controller plus datapath.
// Depends on bfa_pkg, bfa_ctrl, bfa_dp (and bfa_ram through the datapath).
//
// Channel   Direction  Handshake                   Payload
// request   in         i_in_valid / o_in_ready     i_action, i_request_size, i_block_offset
// result    out        o_out_valid / i_out_ready   o_result_offset, o_status
// config    in         i_cfg_we (no wait)          i_cfg_wdata (heap size)
//
// Items are taken one at a time: each is accepted, the descriptor table is read 64 times
// through its single read port, the last read data drains, a decision is taken, up to two
// entries are written back on the single write port and the result is loaded.
// Reset is synchronous and active low; the table contents need no clearing.
// A result that is not taken holds the block in its final step until the output
// register frees up.
`default_nettype none
module best_fit_block_allocator_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_action,
    input  wire logic [31:0] i_request_size,
    input  wire logic [31:0] i_block_offset,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_result_offset,
    output logic [2:0]       o_status
);
    import bfa_pkg::*;

    t_cmd     cmd;
    t_dp_stat stat;

    bfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bfa_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_action        (i_action),
        .i_request_size  (i_request_size),
        .i_block_offset  (i_block_offset),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_result_offset (o_result_offset),
        .o_status        (o_status)
    );
endmodule
`default_nettype wire

@@ test/tb_best_fit_block_allocator_core.sv @@
// Self-checking testbench for best_fit_block_allocator_core: directed table, then random phases.
// A predictor of the descriptor table and the bump pointer forms the expected results.
// Depends on bfa_pkg and the RTL of the block only.
`default_nettype none
module tb_best_fit_block_allocator_core;
    import bfa_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [31:0] i_cfg_wdata = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_action = ACT_ALLOC;
    logic [31:0] i_request_size = '0;
    logic [31:0] i_block_offset = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [31:0] o_result_offset;
    logic [2:0]  o_status;

    localparam logic [1:0] ACT_UNUSED = 2'd3;

    best_fit_block_allocator_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_action(i_action), .i_request_size(i_request_size),
        .i_block_offset(i_block_offset),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_result_offset(o_result_offset), .o_status(o_status)
    );

    always #10 i_clk = ~i_clk;

    // Predictor state: descriptor table, recency counter, bump pointer.
    logic [31:0] pred_heap_bytes;
    logic [31:0] desc_off  [MAX_BLOCKS];
    logic [31:0] desc_size [MAX_BLOCKS];
    logic [15:0] desc_stamp[MAX_BLOCKS];
    bit          desc_busy [MAX_BLOCKS];
    int          desc_count;
    logic [15:0] stamp_ctr;
    logic [31:0] bump_ptr;

    typedef struct packed {
        logic [31:0] offset;
        logic [2:0]  status;
    } t_grant;

    t_grant pending_grants[$];
    int     mismatches = 0;
    int     out_stall_pct = 0;
    int     in_idle_pct = 0;

    function automatic int lookup_desc(logic [31:0] off);
        for (int i = 0; i < desc_count; i++)
            if (desc_off[i] == off) return i;
        return -1;
    endfunction

    function automatic logic [2:0] grant_block(logic [31:0] size, output logic [31:0] off);
        int          best;
        logic [15:0] best_age, age;
        logic [63:0] blk, nb;
        best = -1;
        best_age = '0;
        off = '0;
        if (size == 0) return ST_ZERO;
        for (int i = 0; i < desc_count; i++) begin
            if (desc_busy[i] || desc_size[i] < size) continue;
            age = stamp_ctr - desc_stamp[i];
            if (best < 0 || desc_size[i] < desc_size[best] ||
                (desc_size[i] == desc_size[best] && age < best_age)) begin
                best = i;
                best_age = age;
            end
        end
        if (best >= 0) begin
            desc_busy[best] = 1'b1;
            off = desc_off[best];
            return ST_OK;
        end
        blk = ({32'd0, bump_ptr} + HEADER_BYTES + ALIGN_BYTES - 1) & ~64'(ALIGN_BYTES - 1);
        nb = blk + size + 2 * ALIGN_BYTES;
        if (nb > {32'd0, pred_heap_bytes}) return ST_HEAP;
        if (desc_count >= MAX_BLOCKS) return ST_FULL;
        desc_off[desc_count]   = blk[31:0];
        desc_size[desc_count]  = size;
        desc_busy[desc_count]  = 1'b1;
        desc_stamp[desc_count] = '0;
        desc_count++;
        bump_ptr = nb[31:0];
        off = blk[31:0];
        return ST_OK;
    endfunction

    function automatic logic [2:0] release_block(logic [31:0] off);
        int i;
        if (off == 0) return ST_OK;
        i = lookup_desc(off);
        if (i < 0) return ST_UNKNOWN;
        if (!desc_busy[i]) return ST_DOUBLE;
        desc_busy[i] = 1'b0;
        desc_stamp[i] = stamp_ctr;
        stamp_ctr++;
        return ST_OK;
    endfunction

    function automatic t_grant serve_request(logic [1:0] act, logic [31:0] size,
                                             logic [31:0] off);
        t_grant      g;
        int          i;
        logic [31:0] noff;
        logic [2:0]  st;
        g = '0;
        case (act)
            ACT_ALLOC: g.status = grant_block(size, g.offset);
            ACT_FREE:  g.status = release_block(off);
            ACT_RESIZE: begin
                if (off == 0) begin
                    g.status = grant_block(size, g.offset);
                end else begin
                    i = lookup_desc(off);
                    if (i < 0) g.status = ST_UNKNOWN;
                    else if (!desc_busy[i]) g.status = ST_DOUBLE;
                    else if (size == 0) g.status = release_block(off);
                    else if (size <= desc_size[i]) g.offset = off;
                    else begin
                        st = grant_block(size, noff);
                        g.status = st;
                        if (st == ST_OK) begin
                            void'(release_block(off));
                            g.offset = noff;
                        end
                    end
                end
            end
            default: ;
        endcase
        return g;
    endfunction

    // Result checker: samples the values from before the edge.
    always @(posedge i_clk) begin
        t_grant want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_grants.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: offset %h status %0d",
                             o_result_offset, o_status);
            end else begin
                want = pending_grants.pop_front();
                if (o_result_offset !== want.offset || o_status !== want.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected offset %h status %0d, got %h %0d",
                                 want.offset, want.status, o_result_offset, o_status);
                end
            end
        end
        i_out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    // Places one item on the request channel and returns once it is accepted.
    // Valid is left high so that back-to-back items need no extra edge.
    task automatic issue(logic [1:0] act, logic [31:0] size, logic [31:0] off,
                         bit known, t_grant typed);
        t_grant g;
        if ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < in_idle_pct);
        end
        i_in_valid     <= 1'b1;
        i_action       <= act;
        i_request_size <= size;
        i_block_offset <= off;
        do @(posedge i_clk); while (!o_in_ready);
        g = serve_request(act, size, off);
        pending_grants.push_back(known ? typed : g);
    endtask

    task automatic drain_and_set_heap(logic [31:0] bytes);
        i_in_valid <= 1'b0;
        while (pending_grants.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= bytes;
        pred_heap_bytes = bytes;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 5) return '0;
        if (r < 10) return $urandom;
        if (r < 25 && desc_count > 0) return desc_size[$urandom_range(desc_count - 1)];
        if (r < 30) return 32'h8000_0000 >> $urandom_range(31);
        return $urandom_range(1, 300);
    endfunction

    function automatic logic [31:0] pick_offset();
        int r;
        r = $urandom_range(99);
        if (r < 5) return '0;
        if (r < 12 || desc_count == 0) return $urandom;
        return desc_off[$urandom_range(desc_count - 1)];
    endfunction

    typedef struct {
        logic [1:0]  act;
        logic [31:0] size;
        logic [31:0] off;
        bit          known;
        logic [31:0] r_off;
        logic [2:0]  r_st;
    } t_req_row;

    t_req_row dir_rows[20] = '{
        '{ACT_ALLOC,  32'd0,          32'd0,          1, 32'd0,   ST_ZERO},
        '{ACT_FREE,   32'd0,          32'd0,          1, 32'd0,   ST_OK},
        '{ACT_FREE,   32'd0,          32'h1234,       1, 32'd0,   ST_UNKNOWN},
        '{ACT_UNUSED, 32'hFFFF_FFFF,  32'hFFFF_FFFF,  1, 32'd0,   ST_OK},
        '{ACT_ALLOC,  32'd1,          32'd0,          1, 32'd32,  ST_OK},
        '{ACT_ALLOC,  32'h8000_0000,  32'd0,          1, 32'd0,   ST_HEAP},
        '{ACT_ALLOC,  32'hFFFF_FFFF,  32'd0,          1, 32'd0,   ST_HEAP},
        '{ACT_ALLOC,  32'd48,         32'd0,          1, 32'd112, ST_OK},
        '{ACT_FREE,   32'd0,          32'd32,         1, 32'd0,   ST_OK},
        '{ACT_FREE,   32'd0,          32'd32,         1, 32'd0,   ST_DOUBLE},
        '{ACT_RESIZE, 32'd5,          32'd32,         1, 32'd0,   ST_DOUBLE},
        '{ACT_ALLOC,  32'd1,          32'd0,          1, 32'd32,  ST_OK},
        '{ACT_RESIZE, 32'd1,          32'd32,         1, 32'd32,  ST_OK},
        '{ACT_RESIZE, 32'd100,        32'd32,         0, 32'd0,   ST_OK},
        '{ACT_FREE,   32'd0,          32'd112,        1, 32'd0,   ST_OK},
        '{ACT_ALLOC,  32'd1,          32'd0,          0, 32'd0,   ST_OK},
        '{ACT_RESIZE, 32'd16,         32'd0,          0, 32'd0,   ST_OK},
        '{ACT_RESIZE, 32'd0,          32'd224,        1, 32'd0,   ST_OK},
        '{ACT_RESIZE, 32'd3,          32'h40,         1, 32'd0,   ST_UNKNOWN},
        '{ACT_RESIZE, 32'd0,          32'd0,          1, 32'd0,   ST_ZERO}
    };

    initial begin
        logic [31:0] heaps[5];
        int          idle_in[4];
        int          idle_out[4];
        int          r;
        logic [1:0]  act;
        heaps    = '{32'd64, 32'd4096, 32'hFFFF_FFFF, 32'h8000_0000, 32'd20000};
        idle_in  = '{0, 49, 0, 36};
        idle_out = '{0, 0, 49, 36};
        pred_heap_bytes = HEAP_RESET;
        desc_count = 0;
        stamp_ctr  = '0;
        bump_ptr   = '0;
        for (int i = 0; i < MAX_BLOCKS; i++) desc_busy[i] = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k])
            issue(dir_rows[k].act, dir_rows[k].size, dir_rows[k].off, dir_rows[k].known,
                  t_grant'{dir_rows[k].r_off, dir_rows[k].r_st});

        // Phases cycle through the idling patterns and the heap sizes.
        for (int ph = 0; ph < 8; ph++) begin
            drain_and_set_heap(heaps[ph % 5]);
            in_idle_pct   = idle_in[ph % 4];
            out_stall_pct = idle_out[ph % 4];
            for (int n = 0; n < 155; n++) begin
                r = $urandom_range(99);
                if (r < 40) act = ACT_ALLOC;
                else if (r < 70) act = ACT_FREE;
                else if (r < 96) act = ACT_RESIZE;
                else act = ACT_UNUSED;
                issue(act, pick_size(), pick_offset(), 1'b0, '0);
            end
        end
        i_in_valid <= 1'b0;
        while (pending_grants.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #60_000_000;
        $display("FAILED: results differ");
        $finish;
    end
endmodule
`default_nettype wire

@@ best_fit_block_allocator_core.f @@
rtl/core/bfa_pkg.sv
rtl/core/bfa_ram.sv
rtl/core/bfa_ctrl.sv
rtl/core/bfa_dp.sv
rtl/core/best_fit_block_allocator_core.sv
test/tb_best_fit_block_allocator_core.sv
